/* rtl/core/elfrb_pkg.sv */
// Shared types and constants for the ELF relocation rebase core.
// Holds the transaction structs and relocation type codes; depends on nothing.
package elfrb_pkg;

    // x86 relocation set
    localparam logic [7:0] RT_386_32   = 8'd1;
    localparam logic [7:0] RT_386_PC32 = 8'd2;

    // ARM relocation set
    localparam logic [7:0] RT_ARM_PC24        = 8'd1;
    localparam logic [7:0] RT_ARM_ABS32       = 8'd2;
    localparam logic [7:0] RT_ARM_CALL        = 8'd28;
    localparam logic [7:0] RT_ARM_JUMP24      = 8'd29;
    localparam logic [7:0] RT_ARM_PREL31      = 8'd42;
    localparam logic [7:0] RT_ARM_MOVW_ABS_NC = 8'd43;
    localparam logic [7:0] RT_ARM_MOVT_ABS    = 8'd44;

    localparam logic STATUS_APPLIED      = 1'b0;
    localparam logic STATUS_UNKNOWN_TYPE = 1'b1;

    typedef struct packed {
        logic [7:0]  reloc_type;
        logic [31:0] target_word;
        logic [31:0] old_symbol_value;
        logic [31:0] new_symbol_value;
        logic [15:0] symbol_section;
        logic [15:0] target_section;
        logic [31:0] old_section_addr;
        logic [31:0] new_section_addr;
        logic [31:0] site_offset;
    } reloc_in_t;

    typedef struct packed {
        logic [31:0] patched_word;
        logic        status;
    } reloc_out_t;

endpackage

/* rtl/core/elf_relocation_rebase_patch_core.sv */
// Top level of the ELF relocation rebase core: three-stage patch pipeline.
// Depends on elfrb_pkg for the transaction structs and type codes.
//
// Usage:
//   Input channel  (in_valid / in_stall / in_data): one relocation record per
//   transaction, accepted at a clock edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall / out_data): one patched word and a
//   status per record, taken at an edge with out_valid high and out_stall low.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes arch_is_arm
//   (0 = x86 set, 1 = ARM set); cfg_ready is always high. Write it only while
//   the pipeline is empty.
// Path: records pass the stage 1, 2 and 3 registers to out_valid. Throughput: one
//   record per cycle while out_stall is low; stages 2 and 3 are each one 32-bit add
//   or subtract plus selection: stage 1 decodes the type and forms the symbol and
//   section deltas in parallel, stage 2 adds the addend to the symbol delta, stage 3
//   applies the section delta and re-encodes the word into the output register.
// Stall: each stage holds its record while the one ahead is full and held;
//   empty stages keep filling, so records are neither dropped nor repeated.
//   in_stall rises only when all three stages are full and out_stall is high.
// Reset: rst_n (asynchronous, active low) empties the pipeline and clears
//   arch_is_arm to the x86 set.
module elf_relocation_rebase_patch_core
    import elfrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  reloc_in_t  in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output reloc_out_t out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    // Operation class decided in stage 1 and carried down the pipe.
    typedef enum logic [2:0] {
        K_ERR,     // unknown type: pass the word, flag an error
        K_SAME,    // PC-relative in the same section: pass the word
        K_ABS,     // W + S_new - S_old
        K_PCREL,   // W + S_new - S_old + B_old - B_new
        K_BRANCH,  // 24-bit branch field, same sum on the scaled addend
        K_PREL31,  // W + S_new - (B_new + O), bit 31 cleared
        K_MOVW,    // low-half immediate rebase
        K_MOVT     // high-half immediate rebase
    } kind_t;

    logic arch_is_arm_reg;

    // Stage enables: a stage loads when it is empty or its contents move on.
    logic en1, en2, en3;

    // Stage 1 registers
    logic        v1_reg;
    kind_t       kind1_reg,  kind1_next;
    logic [31:0] w1_reg;
    logic [31:0] add1_reg,   add1_next;
    logic [31:0] symd1_reg,  symd1_next;
    logic [31:0] secd1_reg,  secd1_next;

    // Stage 2 registers
    logic        v2_reg;
    kind_t       kind2_reg;
    logic [31:0] w2_reg;
    logic [31:0] sum2_reg,   sum2_next;
    logic [31:0] secd2_reg;

    // Stage 3 (output) registers
    logic        v3_reg;
    reloc_out_t  out3_reg,   out3_next;

    logic        same_sec;
    logic [31:0] n3;

    assign en3      = !v3_reg || !out_stall;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    assign cfg_ready = 1'b1;
    assign out_valid = v3_reg;
    assign out_data  = out3_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arch_is_arm_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            arch_is_arm_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: decode the type, pick the addend, form the two deltas.
    // ---------------------------------------------------------------------
    assign same_sec = (in_data.target_section == in_data.symbol_section);

    always_comb
    begin
        kind1_next = K_ERR;
        if (!arch_is_arm_reg)
        begin
            unique case (in_data.reloc_type) inside
                RT_386_32:   kind1_next = K_ABS;
                RT_386_PC32: kind1_next = same_sec ? K_SAME : K_PCREL;
                default:     kind1_next = K_ERR;
            endcase
        end
        else
        begin
            unique case (in_data.reloc_type) inside
                RT_ARM_PC24, RT_ARM_CALL, RT_ARM_JUMP24:
                    kind1_next = same_sec ? K_SAME : K_BRANCH;
                RT_ARM_ABS32:       kind1_next = K_ABS;
                RT_ARM_PREL31:      kind1_next = K_PREL31;
                RT_ARM_MOVW_ABS_NC: kind1_next = K_MOVW;
                RT_ARM_MOVT_ABS:    kind1_next = K_MOVT;
                default:            kind1_next = K_ERR;
            endcase
        end
    end

    always_comb
    begin
        // Addend: scaled, sign-extended branch field or the MOVW/MOVT immediate.
        case (kind1_next)
            K_BRANCH:
                add1_next = {{6{in_data.target_word[23]}},
                             in_data.target_word[23:0], 2'b00};
            K_MOVW, K_MOVT:
                add1_next = {16'd0, in_data.target_word[19:16],
                             in_data.target_word[11:0]};
            default:
                add1_next = in_data.target_word;
        endcase

        // MOVT rebases on the upper halves, no borrow from the lower ones.
        // PREL31 takes the new symbol value alone, without the old one.
        if (kind1_next == K_MOVT)
        begin
            symd1_next = {16'd0, in_data.new_symbol_value[31:16]
                                 - in_data.old_symbol_value[31:16]};
        end
        else if (kind1_next == K_PREL31)
        begin
            symd1_next = in_data.new_symbol_value;
        end
        else
        begin
            symd1_next = in_data.new_symbol_value - in_data.old_symbol_value;
        end

        case (kind1_next)
            K_PCREL, K_BRANCH:
                secd1_next = in_data.old_section_addr - in_data.new_section_addr;
            K_PREL31:
                secd1_next = in_data.new_section_addr + in_data.site_offset;
            default:
                secd1_next = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Stage 2: addend plus symbol delta.
    // ---------------------------------------------------------------------
    assign sum2_next = add1_reg + symd1_reg;

    // ---------------------------------------------------------------------
    // Stage 3: apply the section delta and re-encode the word.
    // ---------------------------------------------------------------------
    assign n3 = (kind2_reg == K_PREL31) ? (sum2_reg - secd2_reg)
                                        : (sum2_reg + secd2_reg);

    always_comb
    begin
        out3_next.status = STATUS_APPLIED;
        case (kind2_reg)
            K_ABS, K_PCREL:
                out3_next.patched_word = n3;
            K_BRANCH:
                out3_next.patched_word = {w2_reg[31:24], n3[25:2]};
            K_PREL31:
                out3_next.patched_word = {1'b0, n3[30:0]};
            K_MOVW, K_MOVT:
                out3_next.patched_word = {w2_reg[31:20], n3[15:12],
                                          w2_reg[15:12], n3[11:0]};
            K_ERR:
            begin
                out3_next.patched_word = w2_reg;
                out3_next.status       = STATUS_UNKNOWN_TYPE;
            end
            default:
                out3_next.patched_word = w2_reg;
        endcase
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload: load on enable, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            kind1_reg <= kind1_next;
            w1_reg    <= in_data.target_word;
            add1_reg  <= add1_next;
            symd1_reg <= symd1_next;
            secd1_reg <= secd1_next;
        end
        if (en2)
        begin
            kind2_reg <= kind1_reg;
            w2_reg    <= w1_reg;
            sum2_reg  <= sum2_next;
            secd2_reg <= secd1_reg;
        end
        if (en3)
        begin
            out3_reg <= out3_next;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted transaction did not enter stage 1");

    a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !en3 |=> v2_reg && $stable(sum2_reg) && $stable(w2_reg))
        else $error("stage 2 transaction lost while held");

    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !en2 |=> v1_reg && $stable(add1_reg) && $stable(symd1_reg))
        else $error("stage 1 transaction lost while held");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && out_stall)
        else $error("input stalled with room in the pipeline");

endmodule

/* sim/reloc_patch_checker.sv */
`timescale 1ns / 100ps
// Checker for the relocation rebase core: predicts each patched word and status.
// Depends on elfrb_pkg for the transaction structs and relocation type codes.
module reloc_patch_checker
    import elfrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  reloc_in_t  in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  reloc_out_t out_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    output int         pending,
    output int         fail_count
);

    logic       arm_set;
    reloc_out_t patched_queue[$];

    // Rebase one relocation site under the selected instruction set.
    function automatic reloc_out_t rebase_word(logic arm, reloc_in_t r);
        reloc_out_t  o;
        logic        same_sec;
        logic [31:0] w;
        logic [31:0] addend;
        logic [31:0] n;
        logic [15:0] imm;
        logic [15:0] v;
        w              = r.target_word;
        same_sec       = (r.symbol_section == r.target_section);
        o.patched_word = w;
        o.status       = STATUS_APPLIED;
        if (!arm) begin
            case (r.reloc_type)
                RT_386_32:
                    o.patched_word = r.new_symbol_value + (w - r.old_symbol_value);
                RT_386_PC32:
                    if (!same_sec) begin
                        addend = w - (r.old_symbol_value
                                      - (r.old_section_addr + r.site_offset + 32'd4));
                        o.patched_word = (r.new_symbol_value + addend)
                                         - (r.new_section_addr + r.site_offset + 32'd4);
                    end
                default:
                    o.status = STATUS_UNKNOWN_TYPE;
            endcase
        end
        else begin
            case (r.reloc_type)
                RT_ARM_PC24, RT_ARM_CALL, RT_ARM_JUMP24:
                    if (!same_sec) begin
                        // sign-extend the 24-bit word offset, scaled to bytes
                        addend = {{6{w[23]}}, w[23:0], 2'b00};
                        addend = addend - (r.old_symbol_value
                                           - (r.old_section_addr + r.site_offset + 32'd8));
                        n = (r.new_symbol_value + addend)
                            - (r.new_section_addr + r.site_offset + 32'd8);
                        o.patched_word = {w[31:24], n[25:2]};
                    end
                RT_ARM_ABS32:
                    o.patched_word = r.new_symbol_value + (w - r.old_symbol_value);
                RT_ARM_PREL31:
                begin
                    n = w + r.new_symbol_value - (r.new_section_addr + r.site_offset);
                    o.patched_word = {1'b0, n[30:0]};
                end
                RT_ARM_MOVW_ABS_NC, RT_ARM_MOVT_ABS:
                begin
                    imm = {w[19:16], w[11:0]};
                    if (r.reloc_type == RT_ARM_MOVW_ABS_NC)
                        v = r.new_symbol_value[15:0] + imm - r.old_symbol_value[15:0];
                    else
                        v = r.new_symbol_value[31:16] + imm - r.old_symbol_value[31:16];
                    o.patched_word = {w[31:20], v[15:12], w[15:12], v[11:0]};
                end
                default:
                    o.status = STATUS_UNKNOWN_TYPE;
            endcase
        end
        return o;
    endfunction

    task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        if (fail_count < 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk)
    begin
        reloc_out_t want;
        if (!rst_n) begin
            arm_set = 1'b0;
            patched_queue.delete();
            pending <= 0;
        end
        else begin
            // the input transaction sees the set that was in force before this edge
            if (in_valid && !in_stall)
                patched_queue.push_back(rebase_word(arm_set, in_data));
            if (cfg_valid && cfg_ready)
                arm_set = cfg_data;
            if (out_valid && !out_stall) begin
                if (patched_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result, word %h status %b", $realtime,
                                 out_data.patched_word, out_data.status);
                    fail_count++;
                end
                else begin
                    want = patched_queue.pop_front();
                    if (out_data.patched_word !== want.patched_word)
                        note_mismatch("patched_word", want.patched_word,
                                      out_data.patched_word);
                    if (out_data.status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(out_data.status));
                end
            end
            pending <= patched_queue.size();
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Top of the relocation rebase testbench: clock, reset, stimulus and verdict.
// Depends on elfrb_pkg, elf_relocation_rebase_patch_core and reloc_patch_checker.
module testbench;
    import elfrb_pkg::*;

    // Generous ceiling for ~550 records, plus hold-offs.
    localparam int CYCLE_LIMIT = 200000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    reloc_in_t  in_data;
    logic       out_valid;
    logic       out_stall;
    reloc_out_t out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    int         pending;
    int         fail_count;

    // Idling knobs, in percent per cycle, and a one-shot receiver hold-off.
    int gap_pct   = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;

    elf_relocation_rebase_patch_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    reloc_patch_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: stop the run if the pipeline never drains.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: stall at random, or hold off for a counted stretch on request.
    initial
    begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Mostly random words, with the all-zero, all-one and sign-bit corners mixed in.
    function automatic logic [31:0] any_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic reloc_in_t make_record(logic [7:0] kind, logic [31:0] word,
                                              logic [31:0] sym_old, logic [31:0] sym_new,
                                              logic [15:0] sym_sec, logic [15:0] site_sec,
                                              logic [31:0] base_old, logic [31:0] base_new,
                                              logic [31:0] offset);
        reloc_in_t r;
        r.reloc_type       = kind;
        r.target_word      = word;
        r.old_symbol_value = sym_old;
        r.new_symbol_value = sym_new;
        r.symbol_section   = sym_sec;
        r.target_section   = site_sec;
        r.old_section_addr = base_old;
        r.new_section_addr = base_new;
        r.site_offset      = offset;
        return r;
    endfunction

    // Random record: mostly a type the selected set knows, sometimes any code at all.
    function automatic reloc_in_t random_record(logic arm);
        logic [7:0] arm_kinds [7] = '{RT_ARM_PC24, RT_ARM_CALL, RT_ARM_JUMP24, RT_ARM_ABS32,
                                      RT_ARM_PREL31, RT_ARM_MOVW_ABS_NC, RT_ARM_MOVT_ABS};
        logic [7:0] kind;
        logic [15:0] sym_sec;
        if ($urandom_range(99) < 88)
            kind = arm ? arm_kinds[$urandom_range(6)]
                       : ($urandom_range(1) ? RT_386_32 : RT_386_PC32);
        else
            kind = 8'($urandom_range(255));
        sym_sec = 16'($urandom);
        return make_record(kind, any_word(), any_word(), any_word(), sym_sec,
                           ($urandom_range(99) < 30) ? sym_sec : 16'($urandom),
                           any_word(), any_word(), any_word());
    endfunction

    // Offer one record, idling first at the current gap rate; return at acceptance.
    task automatic send_record(reloc_in_t r);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_arch(logic arm);
        cfg_valid <= 1'b1;
        cfg_data  <= arm;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int n;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, x86 set: extremes, both types, same section, unknown codes.
        write_arch(1'b0);
        send_record(make_record(RT_386_32, '0, '0, '0, '0, '0, '0, '0, '0));
        send_record(make_record(RT_386_32, '1, '1, '1, '1, '1, '1, '1, '1));
        send_record(make_record(RT_386_32, 32'h0000_1000, 32'h0800_0000, 32'hF000_0000,
                                16'd1, 16'd2, 32'h0800_0000, 32'h2000_0000, 32'h10));
        send_record(make_record(RT_386_PC32, 32'hFFFF_FFFC, 32'h0800_1000, 32'h2000_1000,
                                16'd1, 16'd2, 32'h0800_0000, 32'h2000_8000, 32'h40));
        // PC-relative within one section: word passes through untouched
        send_record(make_record(RT_386_PC32, 32'h1234_5678, 32'h0800_1000, 32'h2000_1000,
                                16'd3, 16'd3, 32'h0800_0000, 32'h2000_8000, 32'h40));
        send_record(make_record(8'd0, 32'hDEAD_BEEF, '1, '0, 16'd4, 16'd5, '1, '0, '1));
        send_record(make_record(8'd255, 32'hCAFE_F00D, '0, '1, 16'd4, 16'd5, '0, '1, '0));
        send_record(make_record(RT_ARM_PREL31, 32'h7FFF_FFFF, '1, '1, 16'd6, 16'd7,
                                '1, '1, '1));
        drain();

        // Directed, ARM set: branch signs, same section, every other type, unknown codes.
        write_arch(1'b1);
        send_record(make_record(RT_ARM_PC24, 32'hEB00_0010, 32'h0000_8000, 32'h4000_8000,
                                16'd1, 16'd2, 32'h0000_0000, 32'h4000_1000, 32'h100));
        send_record(make_record(RT_ARM_CALL, 32'hEBFF_FFFE, 32'h0000_8000, 32'h0000_0400,
                                16'd1, 16'd2, 32'h0001_0000, 32'h8000_0000, 32'h24));
        send_record(make_record(RT_ARM_JUMP24, 32'hEA80_0000, '1, '0, 16'hFFFF, 16'h0000,
                                '0, '1, '1));
        send_record(make_record(RT_ARM_PC24, 32'hEB12_3456, 32'h100, 32'h200,
                                16'd9, 16'd9, 32'h0, 32'h1000, 32'h8));
        send_record(make_record(RT_ARM_JUMP24, 32'hEAFF_FFFF, '1, '1, 16'hFFFF, 16'hFFFF,
                                '1, '1, '1));
        send_record(make_record(RT_ARM_ABS32, '1, '0, '1, '0, '1, '0, '1, '0));
        send_record(make_record(RT_ARM_PREL31, 32'h7FFF_FFFF, '1, 32'hFFFF_FF00,
                                16'd1, 16'd2, '1, 32'h0000_0010, 32'h4));
        send_record(make_record(RT_ARM_MOVW_ABS_NC, 32'hE30F_0FFF, 32'h0000_0001,
                                32'hFFFF_FFFF, 16'd1, 16'd1, '0, '0, '0));
        send_record(make_record(RT_ARM_MOVW_ABS_NC, 32'hE300_0000, 32'h1234_FFFF,
                                32'h0000_0000, 16'd1, 16'd2, '0, '0, '0));
        send_record(make_record(RT_ARM_MOVT_ABS, 32'hE34F_0FFF, 32'h0001_0000,
                                32'hFFFF_0000, 16'd1, 16'd2, '0, '0, '0));
        send_record(make_record(RT_ARM_MOVT_ABS, 32'hE340_0000, 32'hFFFF_0000,
                                32'h0000_FFFF, 16'd1, 16'd2, '0, '0, '0));
        send_record(make_record(8'd0, 32'h0BAD_CAFE, '0, '0, 16'd0, 16'd1, '0, '0, '0));
        send_record(make_record(8'd255, '1, '1, '1, 16'd0, 16'd1, '1, '1, '1));
        send_record(make_record(8'd3, 32'h5555_AAAA, '1, '0, 16'd0, 16'd1, '0, '1, '0));
        drain();

        // Random phases: both sets under every idling mix.
        for (int p = 0; p < 8; p++) begin
            case (p / 2)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 52; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 52; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            write_arch(p[0]);
            n = 66;
            for (int i = 0; i < n; i++) begin
                // back up the output for a long stretch while records keep coming
                if (p == 1 && i == 5)
                    hold_left = 40;
                // pause the sender until the pipeline has emptied
                if (p == 4 && i == n / 2)
                    drain();
                send_record(random_record(p[0]));
            end
            drain();
        end

        // Let any stray results surface before the verdict.
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
